>>> design/ncs_pkg.sv
// ============================================================================
// ncs_pkg
// Shared widths, register indexes, operation codes and control structs for
// the nearest-centroid search block.
// ============================================================================
package ncs_pkg;

    localparam int DEF_MAX_CLUSTERS = 64;
    localparam int DEF_MAX_LENGTH   = 64;

    localparam int IDX_W     = 6;    // cluster_index, component_index, nearest_index
    localparam int VAL_W     = 16;   // Q8.8 component
    localparam int SQ_W      = 32;   // square of a 16-bit magnitude
    localparam int DIST_W    = 48;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 32;   // 6 + 6 + 16 = 28 bits, padded to bytes
    localparam int M_DATA_W  = 56;   // 6 + 48 = 54 bits, padded to bytes

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_W-1:0] NUM_CLUSTERS_RST  = 7'd1;
    localparam logic [CFG_W-1:0] VECTOR_LENGTH_RST = 7'd64;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // controller -> datapath
    typedef struct packed {
        logic store;      // input item accepted this cycle
        logic rd_en;      // read one query/codebook pair
        logic first_k;    // first component of a centroid
        logic last_k;     // last component of a centroid
        logic first_cl;   // centroid 0
        logic last_cl;    // last centroid of the search
        logic load_out;   // move best result into the output register
    } ncs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;       // best index/distance final this cycle
        logic out_free;   // output register can take a result
    } ncs_status_t;

endpackage

>>> design/nearest_centroid_search.sv
// ============================================================================
// nearest_centroid_search
// Nearest-codeword search: stores a codebook and a query vector, then finds
// the centroid at the smallest squared Euclidean distance.
// ============================================================================
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  s_      | in  | s_tvalid / s_tready | tuser operation, tdata idx/value, tlast
//  m_      | out | m_tvalid / m_tready | tdata nearest_index, nearest_distance
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
//  Codebook writes and non-final query items are stored as they are accepted.
//  A final query item starts a search over each component of each configured centroid,
//  one component pair per cycle through the shared squared-difference unit,
//  then a pipeline drain; m_tvalid rises and s_tready returns together after that.
//  The input side is held off during a search, and after it for as long as an
//  earlier result still waits on m_.
//  Reset clears control state only; memories are undefined until written.
// ============================================================================
module nearest_centroid_search #(
    parameter int MAX_CLUSTERS = ncs_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_LENGTH   = ncs_pkg::DEF_MAX_LENGTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] cluster_index, [11:6] component_index, [27:12] component_value
    input  logic [ncs_pkg::S_DATA_W-1:0]    s_tdata,
    // [0] operation
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] nearest_index, [53:6] nearest_distance
    output logic [ncs_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ncs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ncs_pkg::CFG_W-1:0]       cfg_data
);
    import ncs_pkg::*;

    localparam int KW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CLW = $clog2(MAX_CLUSTERS);
    localparam int CBW = $clog2(MAX_CLUSTERS * MAX_LENGTH);

    ncs_cmd_t          cmd;
    ncs_status_t       status;
    logic [KW-1:0]     rd_k;
    logic [CBW-1:0]    rd_addr;
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] nearest_distance;

    assign cfg_ready = 1'b1;

    ncs_ctrl #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_LENGTH   (MAX_LENGTH),
        .KW           (KW),
        .CLW          (CLW),
        .CBW          (CBW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .status    (status),
        .cmd       (cmd),
        .rd_k      (rd_k),
        .rd_addr   (rd_addr)
    );

    ncs_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_LENGTH   (MAX_LENGTH),
        .KW           (KW),
        .CLW          (CLW),
        .CBW          (CBW)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .rd_k             (rd_k),
        .rd_addr          (rd_addr),
        .operation        (s_tuser),
        .cluster_index    (s_tdata[5:0]),
        .component_index  (s_tdata[11:6]),
        .component_value  (s_tdata[27:12]),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .nearest_index    (nearest_index),
        .nearest_distance (nearest_distance)
    );

    assign m_tdata = {{(M_DATA_W - IDX_W - DIST_W){1'b0}}, nearest_distance, nearest_index};

endmodule

>>> design/ncs_ctrl.sv
// ============================================================================
// ncs_ctrl
// Search sequencer: holds the configuration registers, takes input items,
// and steps the component and centroid counters during a search.
// ============================================================================
module ncs_ctrl #(
    parameter int MAX_CLUSTERS = ncs_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_LENGTH   = ncs_pkg::DEF_MAX_LENGTH,
    parameter int KW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
    parameter int CLW = $clog2(MAX_CLUSTERS),
    parameter int CBW = $clog2(MAX_CLUSTERS * MAX_LENGTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [ncs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ncs_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           s_tready,
    input  ncs_pkg::ncs_status_t           status,
    output ncs_pkg::ncs_cmd_t              cmd,
    output logic [KW-1:0]                  rd_k,
    output logic [CBW-1:0]                 rd_addr
);
    import ncs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [CLW-1:0]   c_reg, c_next;
    logic [CBW-1:0]   base_reg, base_next;
    logic [CFG_W-1:0] num_clusters_reg, num_clusters_next;
    logic [CFG_W-1:0] vector_length_reg, vector_length_next;

    logic [KW-1:0]    k_last;
    logic [CLW-1:0]   c_last;
    logic             accept;

    // zero counts as one, values above the maximum saturate
    always_comb
    begin
        if (num_clusters_reg == '0)
            c_last = '0;
        else if (32'(num_clusters_reg) > 32'(MAX_CLUSTERS))
            c_last = CLW'(MAX_CLUSTERS - 1);
        else
            c_last = CLW'(num_clusters_reg - 7'd1);

        if (vector_length_reg == '0)
            k_last = '0;
        else if (32'(vector_length_reg) > 32'(MAX_LENGTH))
            k_last = KW'(MAX_LENGTH - 1);
        else
            k_last = KW'(vector_length_reg - 7'd1);
    end

    always_comb
    begin
        num_clusters_next  = num_clusters_reg;
        vector_length_next = vector_length_reg;
        if (cfg_valid)
        begin
            if (cfg_index == REG_NUM_CLUSTERS)
                num_clusters_next = cfg_data;
            else if (cfg_index == REG_VECTOR_LENGTH)
                vector_length_next = cfg_data;
        end
    end

    assign rd_k    = k_reg;
    assign rd_addr = base_reg + CBW'(k_reg);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        base_next  = base_reg;

        s_tready = (state_reg == ST_IDLE);
        accept   = s_tvalid && s_tready;

        cmd          = '0;
        cmd.store    = accept;
        cmd.rd_en    = (state_reg == ST_SCAN);
        cmd.first_k  = (k_reg == '0);
        cmd.last_k   = (k_reg == k_last);
        cmd.first_cl = (c_reg == '0);
        cmd.last_cl  = (c_reg == c_last);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_tuser == OP_QUERY && s_tlast)
                begin
                    state_next = ST_SCAN;
                    k_next     = '0;
                    c_next     = '0;
                    base_next  = '0;
                end
            end
            ST_SCAN:
            begin
                k_next = k_reg + KW'(1);
                if (cmd.last_k)
                begin
                    k_next    = '0;
                    c_next    = c_reg + CLW'(1);
                    base_next = base_reg + CBW'(MAX_LENGTH);
                    if (cmd.last_cl)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.done)
                begin
                    if (status.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            k_reg             <= '0;
            c_reg             <= '0;
            base_reg          <= '0;
            num_clusters_reg  <= NUM_CLUSTERS_RST;
            vector_length_reg <= VECTOR_LENGTH_RST;
        end
        else
        begin
            state_reg         <= state_next;
            k_reg             <= k_next;
            c_reg             <= c_next;
            base_reg          <= base_next;
            num_clusters_reg  <= num_clusters_next;
            vector_length_reg <= vector_length_next;
        end
    end

`ifndef SYNTHESIS
    // a result is never loaded over one that is still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result loaded while output register busy");

    // the datapath finishes only while the sequencer waits for it
    a_done_drain: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> state_reg == ST_DRAIN)
        else $error("search done outside drain");

    // the final read of a search ends the scan
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cmd.last_k && cmd.last_cl) |=> state_reg == ST_DRAIN)
        else $error("scan did not end after last read");
`endif

endmodule

>>> design/ncs_datapath.sv
// ============================================================================
// ncs_datapath
// Codebook and query memories, squared-difference pipeline, saturating
// accumulator, running minimum and output register.
// ============================================================================
module ncs_datapath #(
    parameter int MAX_CLUSTERS = ncs_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_LENGTH   = ncs_pkg::DEF_MAX_LENGTH,
    parameter int KW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
    parameter int CLW = $clog2(MAX_CLUSTERS),
    parameter int CBW = $clog2(MAX_CLUSTERS * MAX_LENGTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ncs_pkg::ncs_cmd_t            cmd,
    output ncs_pkg::ncs_status_t         status,
    input  logic [KW-1:0]                rd_k,
    input  logic [CBW-1:0]               rd_addr,
    input  logic                         operation,
    input  logic [ncs_pkg::IDX_W-1:0]    cluster_index,
    input  logic [ncs_pkg::IDX_W-1:0]    component_index,
    input  logic [ncs_pkg::VAL_W-1:0]    component_value,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [ncs_pkg::IDX_W-1:0]    nearest_index,
    output logic [ncs_pkg::DIST_W-1:0]   nearest_distance
);
    import ncs_pkg::*;

    logic [VAL_W-1:0] cb_mem [MAX_CLUSTERS*MAX_LENGTH];
    logic [VAL_W-1:0] q_mem  [MAX_LENGTH];

    logic             k_ok, c_ok;
    logic             cb_we, q_we;
    logic [CBW-1:0]   wr_addr;

    ncs_cmd_t         t1_reg, t2_reg, t3_reg;
    logic [VAL_W-1:0] q_rd_reg, c_rd_reg;
    logic [16:0]      diff;
    logic [VAL_W-1:0] mag;
    logic [SQ_W-1:0]  sq_reg;
    logic [DIST_W:0]  sum;
    logic [DIST_W-1:0] acc_reg, acc_next;
    logic [DIST_W-1:0] best_d_reg;
    logic [CLW-1:0]   best_i_reg;
    logic [CLW-1:0]   cl_cnt_reg, cur_cl;
    logic             done_reg;
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [DIST_W-1:0] out_dist_reg;

    // out-of-range writes are dropped
    assign k_ok    = 32'(component_index) < 32'(MAX_LENGTH);
    assign c_ok    = 32'(cluster_index) < 32'(MAX_CLUSTERS);
    assign cb_we   = cmd.store && operation == OP_WRITE && k_ok && c_ok;
    assign q_we    = cmd.store && operation == OP_QUERY && k_ok;
    assign wr_addr = CBW'(32'(cluster_index) * MAX_LENGTH + 32'(component_index));

    always_ff @(posedge clk)
    begin
        if (cb_we)
            cb_mem[wr_addr] <= component_value;
        if (cmd.rd_en)
            c_rd_reg <= cb_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[KW'(component_index)] <= component_value;
        if (cmd.rd_en)
            q_rd_reg <= q_mem[rd_k];
    end

    // |q - c| always fits 16 bits unsigned
    always_comb
    begin
        diff = {q_rd_reg[VAL_W-1], q_rd_reg} - {c_rd_reg[VAL_W-1], c_rd_reg};
        mag  = diff[16] ? VAL_W'(17'd0 - diff) : diff[VAL_W-1:0];
    end

    always_comb
    begin
        sum = {1'b0, acc_reg} + (DIST_W+1)'(sq_reg);
        if (t2_reg.first_k)
            acc_next = DIST_W'(sq_reg);
        else if (sum[DIST_W])
            acc_next = DIST_MAX;
        else
            acc_next = sum[DIST_W-1:0];
    end

    assign cur_cl = t3_reg.first_cl ? '0 : cl_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg        <= '0;
            t2_reg        <= '0;
            t3_reg        <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            t1_reg   <= cmd.rd_en ? cmd : '0;
            t2_reg   <= t1_reg;
            t3_reg   <= t2_reg;
            done_reg <= t3_reg.rd_en && t3_reg.last_k && t3_reg.last_cl;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t1_reg.rd_en)
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        if (t2_reg.rd_en)
            acc_reg <= acc_next;
        // strict less-than keeps the lowest index on a tie
        if (t3_reg.rd_en && t3_reg.last_k)
        begin
            cl_cnt_reg <= cur_cl + CLW'(1);
            if (t3_reg.first_cl || acc_reg < best_d_reg)
            begin
                best_d_reg <= acc_reg;
                best_i_reg <= cur_cl;
            end
        end
        if (cmd.load_out)
        begin
            out_idx_reg  <= IDX_W'(best_i_reg);
            out_dist_reg <= best_d_reg;
        end
    end

    assign status.done     = done_reg;
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid         = out_valid_reg;
    assign nearest_index    = out_idx_reg;
    assign nearest_distance = out_dist_reg;

endmodule
